FILE: design/mlfq_pkg.sv
// mlfq_pkg: shared types, constants and table helpers for the mlfq scheduler
// used by mlfq_ram users and the mlfq_scheduler top level; no dependencies
package mlfq_pkg;

    localparam int MAX_JOBS = 16;
    localparam int LEVELS   = 4;
    localparam int ID_W     = $clog2(MAX_JOBS);
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int QA_W     = LVL_W + ID_W;
    localparam int QDEPTH   = LEVELS * MAX_JOBS;
    localparam int TBL_W    = 16;

    localparam logic [2:0]  NUM_LEVELS_RST   = 3'd3;
    localparam logic [63:0] QUANTUM_RST      = 64'h000A_000A_000A_000A;
    localparam logic [63:0] ALLOT_RST        = 64'h0005_0005_0005_0005;
    localparam logic [15:0] BOOST_PERIOD_RST = 16'd100;

    typedef enum logic [1:0] {
        ST_RAN    = 2'd0,
        ST_IDLE   = 2'd1,
        ST_ADDED  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_NUM_LEVELS = 2'd0,
        REG_QUANTUM    = 2'd1,
        REG_ALLOT      = 2'd2,
        REG_BOOST      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_BQ_RD,
        S_BQ_WR,
        S_BJ_RD,
        S_BJ_WR,
        S_PICK,
        S_QRD,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] ticks_left;
        logic [15:0] allot_left;
        logic [15:0] time_left;
        logic        started;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef struct packed {
        status_t     status;
        logic [3:0]  ran_job;
        logic [1:0]  ran_level;
        logic        job_finished;
        logic        first_run;
        logic        boosted;
        logic [31:0] tick_time;
    } res_t;

    function automatic logic [LVL_W-1:0] top_of(logic [2:0] n);
        logic [LVL_W-1:0] t;
        if (n == 3'd0)
            t = '0;
        else if (32'(n) > LEVELS)
            t = LVL_W'(LEVELS - 1);
        else
            t = LVL_W'(n - 3'd1);
        return t;
    endfunction

    // level uses table entry level mod 4
    function automatic logic [15:0] quantum_of(logic [63:0] tbl, logic [LVL_W-1:0] lvl);
        logic [15:0] q;
        logic [1:0]  s;
        s = 2'(lvl);
        q = tbl[{s, 4'b0000} +: TBL_W];
        return (q == 16'd0) ? 16'd1 : q;
    endfunction

    function automatic logic [15:0] allot_of(logic [63:0] tbl, logic [LVL_W-1:0] lvl);
        logic [1:0] s;
        s = 2'(lvl);
        return tbl[{s, 4'b0000} +: TBL_W];
    endfunction

endpackage

FILE: design/mlfq_ram.sv
// mlfq_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/mlfq_scheduler.sv
// mlfq_scheduler: multi-level feedback queue scheduler top level
// uses mlfq_pkg and two mlfq_ram instances (job table and level queues)
//
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | req_type, job_id, run_time
//  out     | out_valid / out_stall  | status, ran_job, ran_level, job_finished,
//          |                        | first_run, boosted, tick_time
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an add holds the block through idle, add and done, a plain tick through idle, pick,
// queue read, run and done (pick goes straight to done when every queue is empty); the
// result beat is raised at the edge that leaves done; a boosting tick first moves queued
// jobs level by level behind the top queue, then refreshes each live job slot by slot
// reset empties all queues through head/count flops; job table needs no clearing
// input is taken only in idle; a stalled result holds the next one in its done state
module mlfq_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [3:0]  job_id,
    input  logic [15:0] run_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  ran_job,
    output logic [1:0]  ran_level,
    output logic        job_finished,
    output logic        first_run,
    output logic        boosted,
    output logic [31:0] tick_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IW = mlfq_pkg::ID_W;
    localparam int LW = mlfq_pkg::LVL_W;
    localparam int CW = mlfq_pkg::CNT_W;
    localparam int NL = mlfq_pkg::LEVELS;
    localparam int NJ = mlfq_pkg::MAX_JOBS;

    mlfq_pkg::state_t state_reg, state_next;

    logic [2:0]  num_levels_reg, num_levels_next;
    logic [63:0] quantum_reg, quantum_next;
    logic [63:0] allot_reg, allot_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] cdn_reg, cdn_next;
    logic [31:0] tick_reg, tick_next;

    logic [NJ-1:0]   live_reg, live_next;
    logic [IW-1:0]   head_reg [NL];
    logic [IW-1:0]   head_next [NL];
    logic [CW-1:0]   cnt_reg [NL];
    logic [CW-1:0]   cnt_next [NL];

    logic            req_reg, req_next;
    logic [IW-1:0]   id_reg, id_next;
    logic [15:0]     rt_reg, rt_next;
    logic            boost_reg, boost_next;
    logic [LW:0]     bl_reg, bl_next;
    logic [IW:0]     bj_reg, bj_next;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [IW-1:0]   job_reg, job_next;

    mlfq_pkg::res_t  res_reg, res_next;
    mlfq_pkg::res_t  out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic                 j_we;
    logic [IW-1:0]        j_waddr, j_raddr;
    mlfq_pkg::job_t       j_wdata, j_rdata;
    logic                 q_we;
    logic [LW+IW-1:0]     q_waddr, q_raddr;
    logic [IW-1:0]        q_wdata, q_rdata;

    logic [LW-1:0]   top;
    logic            any_q;
    logic [LW-1:0]   hi_lvl;
    logic [CW+LW-1:0] q_total;
    logic            in_acc, cfg_acc, out_free;

    mlfq_ram #(.WIDTH(mlfq_pkg::JOB_W), .DEPTH(NJ)) u_job_ram (
        .clk   (clk),
        .we    (j_we),
        .waddr (j_waddr),
        .wdata (j_wdata),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    mlfq_ram #(.WIDTH(IW), .DEPTH(mlfq_pkg::QDEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign top       = mlfq_pkg::top_of(num_levels_reg);
    assign in_stall  = (state_reg != mlfq_pkg::S_IDLE);
    assign cfg_ready = (state_reg == mlfq_pkg::S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;

    // highest non-empty level
    always_comb
    begin
        any_q  = 1'b0;
        hi_lvl = '0;
        q_total = '0;
        for (int l = 0; l < NL; l++)
        begin
            q_total = q_total + (CW+LW)'(cnt_reg[l]);
            if (cnt_reg[l] != '0)
            begin
                any_q  = 1'b1;
                hi_lvl = LW'(l);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        num_levels_next = num_levels_reg;
        quantum_next    = quantum_reg;
        allot_next      = allot_reg;
        period_next     = period_reg;
        cdn_next        = cdn_reg;
        tick_next       = tick_reg;
        live_next       = live_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        rt_next         = rt_reg;
        boost_next      = boost_reg;
        bl_next         = bl_reg;
        bj_next         = bj_reg;
        lvl_next        = lvl_reg;
        job_next        = job_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        j_we            = 1'b0;
        j_waddr         = '0;
        j_wdata         = j_rdata;
        j_raddr         = '0;
        q_we            = 1'b0;
        q_waddr         = '0;
        q_wdata         = '0;
        q_raddr         = '0;

        if (cfg_acc)
        begin
            unique case (mlfq_pkg::cfg_idx_t'(cfg_index))
                mlfq_pkg::REG_NUM_LEVELS: num_levels_next = cfg_data[2:0];
                mlfq_pkg::REG_QUANTUM:    quantum_next = cfg_data;
                mlfq_pkg::REG_ALLOT:      allot_next = cfg_data;
                mlfq_pkg::REG_BOOST:
                begin
                    period_next = cfg_data[15:0];
                    cdn_next    = cfg_data[15:0];
                end
            endcase
        end

        unique case (state_reg)
            mlfq_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next   = req_type;
                    id_next    = job_id;
                    rt_next    = run_time;
                    boost_next = 1'b0;
                    if (mlfq_pkg::req_t'(req_type) == mlfq_pkg::REQ_ADD)
                        state_next = mlfq_pkg::S_ADD;
                    else if (period_reg == 16'd0)
                        state_next = mlfq_pkg::S_PICK;
                    else if (cdn_reg == 16'd0)
                    begin
                        boost_next = 1'b1;
                        cdn_next   = period_reg - 16'd1;
                        bl_next    = '0;
                        state_next = mlfq_pkg::S_BQ_RD;
                    end
                    else
                    begin
                        cdn_next   = cdn_reg - 16'd1;
                        state_next = mlfq_pkg::S_PICK;
                    end
                end
            end

            mlfq_pkg::S_ADD:
            begin
                res_next.status       = live_reg[id_reg] ? mlfq_pkg::ST_REJECT
                                                         : mlfq_pkg::ST_ADDED;
                res_next.ran_job      = 4'(id_reg);
                res_next.ran_level    = 2'(top);
                res_next.job_finished = 1'b0;
                res_next.first_run    = 1'b0;
                res_next.boosted      = 1'b0;
                res_next.tick_time    = tick_reg;
                if (!live_reg[id_reg] && rt_reg != 16'd0)
                begin
                    j_we    = 1'b1;
                    j_waddr = id_reg;
                    j_wdata = '{ticks_left: mlfq_pkg::quantum_of(quantum_reg, top),
                                allot_left: mlfq_pkg::allot_of(allot_reg, top),
                                time_left:  rt_reg,
                                started:    1'b0};
                    live_next[id_reg] = 1'b1;
                    if (cnt_reg[top] < CW'(NJ))
                    begin
                        q_we          = 1'b1;
                        q_waddr       = {top, head_reg[top] + cnt_reg[top][IW-1:0]};
                        q_wdata       = id_reg;
                        cnt_next[top] = cnt_reg[top] + CW'(1);
                    end
                end
                state_next = mlfq_pkg::S_DONE;
            end

            // move queued jobs of every other level behind the top queue
            mlfq_pkg::S_BQ_RD:
            begin
                if (bl_reg == (LW+1)'(NL))
                begin
                    bj_next    = '0;
                    state_next = mlfq_pkg::S_BJ_RD;
                end
                else if (bl_reg[LW-1:0] == top || cnt_reg[bl_reg[LW-1:0]] == '0)
                    bl_next = bl_reg + (LW+1)'(1);
                else
                begin
                    q_raddr = {bl_reg[LW-1:0], head_reg[bl_reg[LW-1:0]]};
                    head_next[bl_reg[LW-1:0]] = head_reg[bl_reg[LW-1:0]] + IW'(1);
                    cnt_next[bl_reg[LW-1:0]]  = cnt_reg[bl_reg[LW-1:0]] - CW'(1);
                    state_next = mlfq_pkg::S_BQ_WR;
                end
            end

            mlfq_pkg::S_BQ_WR:
            begin
                if (cnt_reg[top] < CW'(NJ))
                begin
                    q_we          = 1'b1;
                    q_waddr       = {top, head_reg[top] + cnt_reg[top][IW-1:0]};
                    q_wdata       = q_rdata;
                    cnt_next[top] = cnt_reg[top] + CW'(1);
                end
                state_next = mlfq_pkg::S_BQ_RD;
            end

            // refresh quantum and allotment of every live job
            mlfq_pkg::S_BJ_RD:
            begin
                if (bj_reg == (IW+1)'(NJ))
                    state_next = mlfq_pkg::S_PICK;
                else if (live_reg[bj_reg[IW-1:0]])
                begin
                    j_raddr    = bj_reg[IW-1:0];
                    state_next = mlfq_pkg::S_BJ_WR;
                end
                else
                    bj_next = bj_reg + (IW+1)'(1);
            end

            mlfq_pkg::S_BJ_WR:
            begin
                j_we               = 1'b1;
                j_waddr            = bj_reg[IW-1:0];
                j_wdata            = j_rdata;
                j_wdata.ticks_left = mlfq_pkg::quantum_of(quantum_reg, top);
                j_wdata.allot_left = mlfq_pkg::allot_of(allot_reg, top);
                bj_next            = bj_reg + (IW+1)'(1);
                state_next         = mlfq_pkg::S_BJ_RD;
            end

            mlfq_pkg::S_PICK:
            begin
                if (!any_q)
                begin
                    res_next.status       = mlfq_pkg::ST_IDLE;
                    res_next.ran_job      = '0;
                    res_next.ran_level    = '0;
                    res_next.job_finished = 1'b0;
                    res_next.first_run    = 1'b0;
                    res_next.boosted      = boost_reg;
                    res_next.tick_time    = tick_reg;
                    tick_next             = tick_reg + 32'd1;
                    state_next            = mlfq_pkg::S_DONE;
                end
                else
                begin
                    lvl_next   = hi_lvl;
                    q_raddr    = {hi_lvl, head_reg[hi_lvl]};
                    state_next = mlfq_pkg::S_QRD;
                end
            end

            mlfq_pkg::S_QRD:
            begin
                job_next   = q_rdata;
                j_raddr    = q_rdata;
                state_next = mlfq_pkg::S_RUN;
            end

            mlfq_pkg::S_RUN:
            begin
                j_we               = 1'b1;
                j_waddr            = job_reg;
                j_wdata            = j_rdata;
                j_wdata.started    = 1'b1;
                j_wdata.time_left  = j_rdata.time_left - 16'd1;
                j_wdata.ticks_left = (j_rdata.ticks_left != 16'd0) ?
                                     j_rdata.ticks_left - 16'd1 : 16'd0;

                res_next.status       = mlfq_pkg::ST_RAN;
                res_next.ran_job      = 4'(job_reg);
                res_next.ran_level    = 2'(lvl_reg);
                res_next.job_finished = (j_wdata.time_left == 16'd0);
                res_next.first_run    = !j_rdata.started;
                res_next.boosted      = boost_reg;
                res_next.tick_time    = tick_reg;
                tick_next             = tick_reg + 32'd1;

                if (j_wdata.time_left == 16'd0)
                begin
                    head_next[lvl_reg] = head_reg[lvl_reg] + IW'(1);
                    cnt_next[lvl_reg]  = cnt_reg[lvl_reg] - CW'(1);
                    live_next[job_reg] = 1'b0;
                end
                else if (j_wdata.ticks_left == 16'd0)
                begin
                    head_next[lvl_reg] = head_reg[lvl_reg] + IW'(1);
                    if (lvl_reg != '0 && j_rdata.allot_left <= 16'd1)
                    begin
                        // demote one level
                        cnt_next[lvl_reg]  = cnt_reg[lvl_reg] - CW'(1);
                        j_wdata.ticks_left = mlfq_pkg::quantum_of(quantum_reg,
                                                                  lvl_reg - LW'(1));
                        j_wdata.allot_left = mlfq_pkg::allot_of(allot_reg,
                                                                lvl_reg - LW'(1));
                        if (cnt_reg[lvl_reg - LW'(1)] < CW'(NJ))
                        begin
                            q_we    = 1'b1;
                            q_waddr = {lvl_reg - LW'(1),
                                       head_reg[lvl_reg - LW'(1)] +
                                       cnt_reg[lvl_reg - LW'(1)][IW-1:0]};
                            q_wdata = job_reg;
                            cnt_next[lvl_reg - LW'(1)] = cnt_reg[lvl_reg - LW'(1)] + CW'(1);
                        end
                    end
                    else
                    begin
                        // back of the same queue, count unchanged
                        j_wdata.ticks_left = mlfq_pkg::quantum_of(quantum_reg, lvl_reg);
                        if (j_rdata.allot_left != 16'd0)
                            j_wdata.allot_left = j_rdata.allot_left - 16'd1;
                        q_we    = 1'b1;
                        q_waddr = {lvl_reg, head_reg[lvl_reg] + cnt_reg[lvl_reg][IW-1:0]};
                        q_wdata = job_reg;
                    end
                end
                state_next = mlfq_pkg::S_DONE;
            end

            mlfq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = mlfq_pkg::S_IDLE;
                end
            end

            default:
                state_next = mlfq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mlfq_pkg::S_IDLE;
            num_levels_reg <= mlfq_pkg::NUM_LEVELS_RST;
            quantum_reg    <= mlfq_pkg::QUANTUM_RST;
            allot_reg      <= mlfq_pkg::ALLOT_RST;
            period_reg     <= mlfq_pkg::BOOST_PERIOD_RST;
            cdn_reg        <= mlfq_pkg::BOOST_PERIOD_RST;
            tick_reg       <= '0;
            live_reg       <= '0;
            for (int l = 0; l < NL; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_levels_reg <= num_levels_next;
            quantum_reg    <= quantum_next;
            allot_reg      <= allot_next;
            period_reg     <= period_next;
            cdn_reg        <= cdn_next;
            tick_reg       <= tick_next;
            live_reg       <= live_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        id_reg    <= id_next;
        rt_reg    <= rt_next;
        boost_reg <= boost_next;
        bl_reg    <= bl_next;
        bj_reg    <= bj_next;
        lvl_reg   <= lvl_next;
        job_reg   <= job_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign ran_job      = out_reg.ran_job;
    assign ran_level    = out_reg.ran_level;
    assign job_finished = out_reg.job_finished;
    assign first_run    = out_reg.first_run;
    assign boosted      = out_reg.boosted;
    assign tick_time    = out_reg.tick_time;

    // every live job sits in exactly one queue when idle
    a_queued_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlfq_pkg::S_IDLE) |-> (32'(q_total) == $countones(live_reg)))
        else $error("queue occupancy differs from live job count");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlfq_pkg::S_DONE && !out_free) |=> (state_reg == mlfq_pkg::S_DONE))
        else $error("result dropped while output beat stalled");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && !in_valid) |=> (state_reg == mlfq_pkg::S_IDLE))
        else $error("config write started work");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> (tick_reg == $past(tick_reg) + 32'd1))
        else $error("tick counter jumped");

    a_req_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlfq_pkg::S_ADD) |-> (req_reg == 1'b0))
        else $error("add path entered on a tick");

endmodule
